/* hdl/assert_macros.svh */
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/lfr_pkg.sv */
// shared types and constants of the line fraction reducer
package lfr_pkg;

   localparam int unsigned COORD_BITS_DEF  = 16;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SETUP,
      BK_GCD,
      BK_DIV,
      BK_FIX
   } back_state_type;

endpackage

/* hdl/lfr_front.sv */
// front end: takes a beat, forms differences and cross products, pushes to the queue
module lfr_front #(
   parameter int unsigned COORD_BITS = lfr_pkg::COORD_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [COORD_BITS-1:0]             req_first_x,
   input  logic signed [COORD_BITS-1:0]             req_first_y,
   input  logic signed [COORD_BITS-1:0]             req_second_x,
   input  logic signed [COORD_BITS-1:0]             req_second_y,
   input  lfr_pkg::fifo_stat_type                   q_stat,
   output logic                                     push,
   output logic [3*(COORD_BITS+1)+2*COORD_BITS+1:0] push_data
);
   import lfr_pkg::*;

   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned PW = 2 * COORD_BITS + 1;
   localparam int unsigned MW = 2 * COORD_BITS;

   logic                 valid_ff, valid_in;
   logic signed [DW-1:0] sn_ff, sn_in, sd_ff, sd_in, bd_ff, bd_in;
   logic signed [MW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic                 vert_ff, vert_in;
   logic                 accept;
   logic signed [DW-1:0] x1, y1, x2, y2;
   logic signed [PW-1:0] bn;

   assign x1 = DW'(req_first_x);
   assign y1 = DW'(req_first_y);
   assign x2 = DW'(req_second_x);
   assign y2 = DW'(req_second_y);

   assign accept = start && !valid_ff;
   assign busy   = valid_ff;
   assign push   = valid_ff && !q_stat.full;

   // one multiplier per cross product, registered before the subtract
   assign sn_in   = y1 - y2;
   assign sd_in   = x1 - x2;
   assign bd_in   = x2 - x1;
   assign p1_in   = MW'(req_second_x) * MW'(req_first_y);
   assign p2_in   = MW'(req_first_x) * MW'(req_second_y);
   assign vert_in = (req_first_x == req_second_x);

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end else if (accept) begin
         valid_in = 1'b1;
      end
   end

   assign bn        = PW'(p1_ff) - PW'(p2_ff);
   assign push_data = {vert_ff, sn_ff, sd_ff, bn, bd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sn_ff   <= sn_in;
         sd_ff   <= sd_in;
         bd_ff   <= bd_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         vert_ff <= vert_in;
      end
   end

endmodule

/* hdl/lfr_queue.sv */
// short fifo between front and back, registered read
module lfr_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = lfr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output lfr_pkg::fifo_stat_type q_stat
);
   import lfr_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign q_stat.full  = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_data     = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

/* hdl/lfr_back.sv */
// back end: binary gcd and exact division of each fraction, then the result strobe
module lfr_back #(
   parameter int unsigned COORD_BITS = lfr_pkg::COORD_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lfr_pkg::fifo_stat_type                   q_stat,
   input  logic [3*(COORD_BITS+1)+2*COORD_BITS+1:0] pop_data,
   output logic                                     pop,
   output logic                                     rsp_valid,
   output logic signed [COORD_BITS:0]               rsp_slope_num,
   output logic signed [COORD_BITS:0]               rsp_slope_den,
   output logic signed [2*COORD_BITS:0]             rsp_icept_num,
   output logic signed [COORD_BITS:0]               rsp_icept_den,
   output logic                                     rsp_vertical
);
   import lfr_pkg::*;

   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned PW = 2 * COORD_BITS + 1;
   localparam int unsigned KW = $clog2(PW + 1);
   localparam int unsigned CW = $clog2(PW);

   back_state_type       state_ff, state_in;
   logic                 phase_ff, phase_in;
   logic                 out_valid_ff, out_valid_in;

   logic signed [PW-1:0] num_ff, num_in, den_ff, den_in;
   logic signed [PW-1:0] ent_bn_ff, ent_bn_in;
   logic signed [DW-1:0] ent_bd_ff, ent_bd_in;
   logic                 vert_ff, vert_in;
   logic [PW-1:0]        a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [PW-1:0]        rn_ff, rn_in, rd_ff, rd_in, qn_ff, qn_in, qd_ff, qd_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [DW-1:0] res_sn_ff, res_sn_in, res_sd_ff, res_sd_in;
   logic signed [PW-1:0] res_bn_ff, res_bn_in;
   logic signed [DW-1:0] res_bd_ff, res_bd_in;
   logic                 res_vert_ff, res_vert_in;

   logic                 f_vert;
   logic signed [DW-1:0] f_sn, f_sd, f_bd;
   logic signed [PW-1:0] f_bn;

   logic                 num_neg, den_neg;
   logic [PW-1:0]        num_mag, den_mag;
   logic [PW:0]          rn_sh, rd_sh;
   logic                 n_ge, d_ge;
   logic [PW-1:0]        rn_next, rd_next;
   logic signed [PW-1:0] red_num, red_den;

   assign {f_vert, f_sn, f_sd, f_bn, f_bd} = pop_data;

   assign num_neg = num_ff[PW-1];
   assign den_neg = den_ff[PW-1];
   assign num_mag = num_neg ? -num_ff : num_ff;
   assign den_mag = den_neg ? -den_ff : den_ff;

   // one restoring division step on each part
   assign rn_sh   = {rn_ff, qn_ff[PW-1]};
   assign rd_sh   = {rd_ff, qd_ff[PW-1]};
   assign n_ge    = (rn_sh >= {1'b0, g_ff});
   assign d_ge    = (rd_sh >= {1'b0, g_ff});
   assign rn_next = n_ge ? PW'(rn_sh - {1'b0, g_ff}) : rn_sh[PW-1:0];
   assign rd_next = d_ge ? PW'(rd_sh - {1'b0, g_ff}) : rd_sh[PW-1:0];

   // put the signs back on the quotients
   assign red_num = num_neg ? -qn_ff : qn_ff;
   assign red_den = den_neg ? -qd_ff : qd_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      out_valid_in = 1'b0;
      pop          = 1'b0;
      num_in       = num_ff;
      den_in       = den_ff;
      ent_bn_in    = ent_bn_ff;
      ent_bd_in    = ent_bd_ff;
      vert_in      = vert_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      cnt_in       = cnt_ff;
      res_sn_in    = res_sn_ff;
      res_sd_in    = res_sd_ff;
      res_bn_in    = res_bn_ff;
      res_bd_in    = res_bd_ff;
      res_vert_in  = res_vert_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            num_in    = PW'(f_sn);
            den_in    = PW'(f_sd);
            ent_bn_in = f_bn;
            ent_bd_in = f_bd;
            vert_in   = f_vert;
            phase_in  = 1'b0;
            state_in  = BK_SETUP;
         end
         BK_SETUP: begin
            if (num_ff == '0 || den_ff == '0) begin
               // zero part: quotients are the magnitudes, fix restores the values
               qn_in    = num_mag;
               qd_in    = den_mag;
               state_in = BK_FIX;
            end else begin
               a_in     = num_mag;
               b_in     = den_mag;
               k_in     = '0;
               state_in = BK_GCD;
            end
         end
         BK_GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               g_in     = PW'((a_ff | b_ff) << k_ff);
               rn_in    = '0;
               rd_in    = '0;
               qn_in    = num_mag;
               qd_in    = den_mag;
               cnt_in   = '0;
               state_in = BK_DIV;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         BK_DIV: begin
            rn_in  = rn_next;
            rd_in  = rd_next;
            qn_in  = {qn_ff[PW-2:0], n_ge};
            qd_in  = {qd_ff[PW-2:0], d_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = BK_FIX;
            end
         end
         BK_FIX: begin
            if (!phase_ff) begin
               res_sn_in = DW'(red_num);
               res_sd_in = DW'(red_den);
               num_in    = ent_bn_ff;
               den_in    = PW'(ent_bd_ff);
               phase_in  = 1'b1;
               state_in  = BK_SETUP;
            end else begin
               res_bn_in    = red_num;
               res_bd_in    = DW'(red_den);
               res_vert_in  = vert_ff;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      ent_bn_ff   <= ent_bn_in;
      ent_bd_ff   <= ent_bd_in;
      vert_ff     <= vert_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      g_ff        <= g_in;
      k_ff        <= k_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      qn_ff       <= qn_in;
      qd_ff       <= qd_in;
      cnt_ff      <= cnt_in;
      res_sn_ff   <= res_sn_in;
      res_sd_ff   <= res_sd_in;
      res_bn_ff   <= res_bn_in;
      res_bd_ff   <= res_bd_in;
      res_vert_ff <= res_vert_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_slope_num = res_sn_ff;
   assign rsp_slope_den = res_sd_ff;
   assign rsp_icept_num = res_bn_ff;
   assign rsp_icept_den = res_bd_ff;
   assign rsp_vertical  = res_vert_ff;

endmodule

/* hdl/line_fraction_reducer_core.sv */
// top level of the line fraction reducer: front end, queue, back end
//
// channel    direction  handshake            beat contents
// request    in         start high, busy low first_x, first_y, second_x, second_y
// response   out        rsp_valid strobe     slope_num/den, icept_num/den, vertical
//
// front end takes a beat, then is busy for one cycle while it subtracts the registered
// cross products and pushes the entry into the queue; it stays busy while the queue is full
// back end per fraction: setup, binary gcd steps, restoring division steps, then fix;
// a fraction with a zero part goes from setup straight to fix; idle pops and fetch loads
// each beat, and the single gcd/divide unit then reduces slope and intercept in turn
// reset is synchronous and clears the queue and both sequencers; no clearing pass
// the receiver cannot stall: each response is marked by rsp_valid for exactly one cycle
`include "assert_macros.svh"

module line_fraction_reducer_core #(
   parameter int unsigned COORD_BITS  = lfr_pkg::COORD_BITS_DEF,
   parameter int unsigned QUEUE_DEPTH = lfr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS:0]   rsp_slope_num,
   output logic signed [COORD_BITS:0]   rsp_slope_den,
   output logic signed [2*COORD_BITS:0] rsp_icept_num,
   output logic signed [COORD_BITS:0]   rsp_icept_den,
   output logic                         rsp_vertical
);
   import lfr_pkg::*;

   // queue entry: vertical flag, slope num/den, intercept num/den
   localparam int unsigned ENTRY_W = 3 * (COORD_BITS + 1) + 2 * COORD_BITS + 2;

   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_push_data;
   logic [ENTRY_W-1:0] q_pop_data;
   fifo_stat_type      q_stat;
   logic               rsp_vert_beat;
   logic               rsp_dens_zero;

   // front end: accept and form differences and cross products
   lfr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .q_stat       (q_stat),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   // decouples the front end from the long back end
   lfr_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_stat    (q_stat)
   );

   // back end: reduce slope then intercept, then strobe the response
   lfr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .pop_data      (q_pop_data),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_slope_num (rsp_slope_num),
      .rsp_slope_den (rsp_slope_den),
      .rsp_icept_num (rsp_icept_num),
      .rsp_icept_den (rsp_icept_den),
      .rsp_vertical  (rsp_vertical)
   );

   // terms for the vertical-line check
   assign rsp_vert_beat = rsp_valid && rsp_vertical;
   assign rsp_dens_zero = (rsp_slope_den == '0) && (rsp_icept_den == '0);

   // response strobes never come back to back
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // an accepted beat makes the front end busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the front end never pushes into a full queue
   `ASSERT_IMPLIES(a_push_room, clock, reset, q_push, !q_stat.full)
   // a vertical line leaves both denominators at zero
   `ASSERT_IMPLIES(a_vert_den, clock, reset, rsp_vert_beat, rsp_dens_zero)

endmodule

/* tb/line_fraction_reducer_checker.sv */
// checker for the line fraction reducer: predicts each response beat and compares it
module line_fraction_reducer_checker
   import lfr_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   input  logic                         rsp_valid,
   input  logic signed [COORD_BITS:0]   rsp_slope_num,
   input  logic signed [COORD_BITS:0]   rsp_slope_den,
   input  logic signed [2*COORD_BITS:0] rsp_icept_num,
   input  logic signed [COORD_BITS:0]   rsp_icept_den,
   input  logic                         rsp_vertical,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           vertical_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [COORD_BITS:0]   slope_num;
      logic signed [COORD_BITS:0]   slope_den;
      logic signed [2*COORD_BITS:0] icept_num;
      logic signed [COORD_BITS:0]   icept_den;
      logic                         vertical;
   } line_beat_t;

   line_beat_t expected_lines[$];
   int fails    = 0;
   int pending  = 0;
   int checked  = 0;
   int verticals = 0;

   assign fail_count     = fails;
   assign pending_count  = pending;
   assign checked_count  = checked;
   assign vertical_count = verticals;

   // gcd of the magnitudes; 1 when either part is zero so the fraction stays as is
   function automatic longint common_factor(input longint num, input longint den);
      longint a;
      longint b;
      longint t;
      if (num == 0 || den == 0) return 1;
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic line_beat_t line_fractions(
      input logic signed [COORD_BITS-1:0] x1,
      input logic signed [COORD_BITS-1:0] y1,
      input logic signed [COORD_BITS-1:0] x2,
      input logic signed [COORD_BITS-1:0] y2
   );
      longint sn;
      longint sd;
      longint bn;
      longint bd;
      longint g;
      line_beat_t r;
      sn = longint'(y1) - longint'(y2);
      sd = longint'(x1) - longint'(x2);
      bn = longint'(x2) * longint'(y1) - longint'(x1) * longint'(y2);
      bd = longint'(x2) - longint'(x1);
      g  = common_factor(sn, sd);
      sn = sn / g;
      sd = sd / g;
      g  = common_factor(bn, bd);
      bn = bn / g;
      bd = bd / g;
      r.slope_num = sn[COORD_BITS:0];
      r.slope_den = sd[COORD_BITS:0];
      r.icept_num = bn[2*COORD_BITS:0];
      r.icept_den = bd[COORD_BITS:0];
      r.vertical  = (x1 == x2);
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : monitor
      line_beat_t want;
      if (!reset) begin
         // responses first: a beat accepted on this edge cannot be answered on it
         if (rsp_valid) begin
            if (expected_lines.size() == 0) begin
               $error("response beat with no request outstanding");
               fails++;
            end else begin
               want = expected_lines.pop_front();
               check_field("slope_num", want.slope_num, rsp_slope_num);
               check_field("slope_den", want.slope_den, rsp_slope_den);
               check_field("icept_num", want.icept_num, rsp_icept_num);
               check_field("icept_den", want.icept_den, rsp_icept_den);
               check_field("vertical", want.vertical, rsp_vertical);
               checked++;
               if (want.vertical) verticals++;
            end
         end
         if (start && !busy)
            expected_lines.push_back(line_fractions(req_first_x, req_first_y,
                                                    req_second_x, req_second_y));
         pending = expected_lines.size();
      end
   end

endmodule

/* tb/line_fraction_reducer_core_tb.sv */
// testbench top for the line fraction reducer: stimulus, checker hookup and verdict
module line_fraction_reducer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lfr_pkg::*;

   localparam int CB           = COORD_BITS_DEF;
   localparam int RANDOM_BEATS = 1850;
   localparam int IDLE_PCT     = 37;
   // covers the back end work of every beat plus sender gaps, with ample margin
   localparam int CYCLE_LIMIT  = 2_500_000;
   // tail after the last response
   localparam int DRAIN_CYCLES = 400;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 busy;
   logic signed [CB-1:0] req_first_x  = '0;
   logic signed [CB-1:0] req_first_y  = '0;
   logic signed [CB-1:0] req_second_x = '0;
   logic signed [CB-1:0] req_second_y = '0;
   logic                 rsp_valid;
   logic signed [CB:0]   rsp_slope_num;
   logic signed [CB:0]   rsp_slope_den;
   logic signed [2*CB:0] rsp_icept_num;
   logic signed [CB:0]   rsp_icept_den;
   logic                 rsp_vertical;

   int  fail_count;
   int  pending_count;
   int  checked_count;
   int  vertical_count;
   int  beats_sent  = 0;
   int  cycle_count = 0;
   bit  idle_ok     = 1'b1;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   line_fraction_reducer_core #(
      .COORD_BITS(CB)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .rsp_valid    (rsp_valid),
      .rsp_slope_num(rsp_slope_num),
      .rsp_slope_den(rsp_slope_den),
      .rsp_icept_num(rsp_icept_num),
      .rsp_icept_den(rsp_icept_den),
      .rsp_vertical (rsp_vertical)
   );

   line_fraction_reducer_checker #(
      .COORD_BITS(CB)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_first_x   (req_first_x),
      .req_first_y   (req_first_y),
      .req_second_x  (req_second_x),
      .req_second_y  (req_second_y),
      .rsp_valid     (rsp_valid),
      .rsp_slope_num (rsp_slope_num),
      .rsp_slope_den (rsp_slope_den),
      .rsp_icept_num (rsp_icept_num),
      .rsp_icept_den (rsp_icept_den),
      .rsp_vertical  (rsp_vertical),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .vertical_count(vertical_count)
   );

   // called at a falling edge, returns at the falling edge after the beat is taken;
   // start stays high between back-to-back beats, so it is never dropped and raised
   // in the same step
   task automatic send_beat(input int x1, input int y1, input int x2, input int y2);
      // random sender gaps, skipped in the no-idle stretch
      while (idle_ok && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_first_x  <= x1[CB-1:0];
      req_first_y  <= y1[CB-1:0];
      req_second_x <= x2[CB-1:0];
      req_second_y <= y2[CB-1:0];
      // beat is taken at the rising edge where busy is low
      do @(posedge clock); while (busy);
      @(negedge clock);
      beats_sent++;
   endtask

   function automatic int signed_range(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // coordinates at or next to the ends of the range and around zero
   function automatic int corner_value();
      case ($urandom_range(0, 6))
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   task automatic send_random_beat();
      int mode;
      int x1;
      int y1;
      int x2;
      int y2;
      int k;
      int dx;
      int dy;
      int m;
      mode = $urandom_range(0, 99);
      // full range by default: every input bit toggles
      x1 = int'($urandom);
      y1 = int'($urandom);
      x2 = int'($urandom);
      y2 = int'($urandom);
      if (mode < 35) begin
         // keep full range values
      end else if (mode < 55) begin
         // small coordinates, so common factors show up often
         x1 = signed_range(-64, 64);
         y1 = signed_range(-64, 64);
         x2 = signed_range(-64, 64);
         y2 = signed_range(-64, 64);
      end else if (mode < 65) begin
         // second point a multiple of a step away: slope often reducible
         x1 = signed_range(-1000, 1000);
         y1 = signed_range(-1000, 1000);
         k  = signed_range(1, 20);
         dx = signed_range(-50, 50);
         dy = signed_range(-50, 50);
         x2 = x1 + k * dx;
         y2 = y1 + k * dy;
      end else if (mode < 73) begin
         // vertical line
         x2 = x1;
      end else if (mode < 81) begin
         // horizontal line, zero slope numerator
         y2 = y1;
      end else if (mode < 86) begin
         // identical points
         x2 = x1;
         y2 = y1;
      end else if (mode < 93) begin
         x1 = corner_value();
         y1 = corner_value();
         x2 = corner_value();
         y2 = corner_value();
      end else begin
         // line through the origin, zero intercept numerator
         m  = signed_range(-100, 100);
         x1 = signed_range(-300, 300);
         x2 = signed_range(-300, 300);
         y1 = m * x1;
         y2 = m * x2;
      end
      send_beat(x1, y1, x2, y2);
   endtask

   // cycle counter guarding against a hang
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_count);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      // synchronous reset held, then released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats: corners, zero parts, vertical, identical, negative dens
      send_beat(0, 0, 0, 0);                     // identical points at origin
      send_beat(32767, 32767, 32767, 32767);     // identical points at max
      send_beat(-32768, -32768, -32768, -32768); // identical points at min
      send_beat(-32768, -32768, 32767, 32767);   // full diagonal, zero intercept
      send_beat(-32768, 32767, 32767, -32768);   // anti-diagonal, largest products
      send_beat(32767, -32768, -32768, 32767);
      send_beat(-32768, 32767, -32768, -32768);  // vertical at min x
      send_beat(32767, 5, 32767, -7);            // vertical at max x
      send_beat(1, 9, -3, 9);                    // horizontal, zero slope numerator
      send_beat(2, 4, 6, 12);                    // through origin
      send_beat(4, 6, 8, 10);                    // both fractions reducible
      send_beat(3, 1, 1, 3);                     // negative slope
      send_beat(0, -32768, 1, 32767);            // largest slope numerator
      send_beat(-1, -1, 1, 1);
      send_beat(10, 0, -10, 0);                  // on the x axis
      send_beat(0, 100, 0, -100);                // vertical on the y axis
      send_beat(12345, -23456, -31000, 30001);
      send_beat(-32768, 0, 0, -32768);
      send_beat(32767, -32768, -32767, 32767);
      send_beat(6, 9, -6, -9);
      send_beat(1, 0, 0, 1);
      send_beat(-32768, -32768, -32767, -32767); // negative slope den that stays negative

      // random beats with a back-to-back stretch in the middle
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         idle_ok = !(i >= 600 && i < 900);
         send_random_beat();
      end
      start <= 1'b0;

      // drain: every expected response in, then a quiet tail
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d request beats over %0d cycles: %0d responses checked, %0d vertical",
               beats_sent, cycle_count, checked_count, vertical_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/lfr_pkg.sv
hdl/lfr_front.sv
hdl/lfr_queue.sv
hdl/lfr_back.sv
hdl/line_fraction_reducer_core.sv
tb/line_fraction_reducer_checker.sv
tb/line_fraction_reducer_core_tb.sv
